[hw/rtl/thermocouple_reading_to_lcd_digits_defines.svh]
// Assertion macros shared by the RTL of the thermocouple LCD digit block.
`ifndef THERMOCOUPLE_READING_TO_LCD_DIGITS_DEFINES_SVH
`define THERMOCOUPLE_READING_TO_LCD_DIGITS_DEFINES_SVH

// Condition must hold on every clock edge out of reset.
`define TC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tc2lcd_pkg.sv]
// Types and constants shared by the thermocouple LCD digit block.
`timescale 1ns / 1ps

package tc2lcd_pkg;

  // Decimal digits of one reading, as handed from front to back.
  typedef struct packed {
    logic [3:0] d3;      // thousands (0 or 1)
    logic [3:0] d2;      // hundreds
    logic [3:0] d1;      // tens
    logic [3:0] d0;      // ones
    logic [3:0] tenths;  // tenths of a degree
  } digits_t;

  // One queue slot: valid plus digits.
  typedef struct packed {
    logic    valid;
    digits_t digits;
  } entry_t;

  localparam int         READING_W    = 12;
  localparam int         COL_W        = 3;

  localparam logic [7:0] LINE2_BASE   = 8'hC0;
  localparam logic [7:0] FIRST_COLUMN = 8'h04;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_SPACE  = 8'h20;
  localparam logic [7:0] ASCII_DOT    = 8'h2E;
  localparam logic [7:0] DEGREE_SIGN  = 8'hDF;
  localparam logic [7:0] ASCII_C      = 8'h43;

  // Character position within one run of eight writes.
  localparam logic [COL_W-1:0] COL_THOUSANDS = 3'd0;
  localparam logic [COL_W-1:0] COL_HUNDREDS  = 3'd1;
  localparam logic [COL_W-1:0] COL_TENS      = 3'd2;
  localparam logic [COL_W-1:0] COL_ONES      = 3'd3;
  localparam logic [COL_W-1:0] COL_DOT       = 3'd4;
  localparam logic [COL_W-1:0] COL_TENTHS    = 3'd5;
  localparam logic [COL_W-1:0] COL_DEGREE    = 3'd6;
  localparam logic [COL_W-1:0] COL_UNIT      = 3'd7;

  localparam logic [7:0] ADDR_FIRST = LINE2_BASE + FIRST_COLUMN;
  localparam logic [7:0] ADDR_LAST  = LINE2_BASE + FIRST_COLUMN + {5'd0, COL_UNIT};

endpackage

[hw/rtl/thermocouple_reading_to_lcd_digits.sv]
// Top level: converter frame to eight LCD DDRAM writes with leading-zero blanking.
// The first write follows the pipeline, the queue, the sequencer and the output registers.
// Eight writes follow back to back; the sequencer emits one write a cycle during a run.
// The receiver cannot stall; busy rises only when the digit queue credits run out.
// Reset (rst, synchronous, active high) empties pipeline, queue and sequencer; no strobe.
`timescale 1ns / 1ps
`include "thermocouple_reading_to_lcd_digits_defines.svh"

module thermocouple_reading_to_lcd_digits
  import tc2lcd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4  // digit queue slots, at least 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] raw_frame,
  output logic        strobe,
  output logic [7:0]  ddram_address,
  output logic [7:0]  char_code,
  output logic        last
);

  // Front to queue: one digit set per converted frame, once it leaves the conversion pipeline.
  entry_t push;
  // Queue head to back end; pop frees one front-end credit.
  entry_t head;
  logic   pop;

  // Front end: bit 15 and bits 2..0 of the frame are dropped, the 12-bit
  // quarter-degree reading is split into thousands/hundreds/tens/ones and
  // a tenths digit through a fixed five-stage pipeline. It never stalls;
  // instead it only takes a frame while a queue slot is reserved for it.
  tc2lcd_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .raw_frame (raw_frame),
    .pop       (pop),
    .busy      (busy),
    .push      (push)
  );

  // Queue decouples the front end from the write sequencer.
  tc2lcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head)
  );

  // Back end: eight writes per reading, columns 4..11 of line 2, with
  // blanking of leading zeros in the thousands, hundreds and tens places.
  // It pulls the next reading on the last write, so runs follow without gaps.
  tc2lcd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .strobe        (strobe),
    .ddram_address (ddram_address),
    .char_code     (char_code),
    .last          (last)
  );

  // The sequencer only takes digits that are in the queue.
  `TC_ASSERT_SAME(a_pop_has_data, pop, head.valid, "pop from empty digit queue")
  // A run of writes, once started, carries on until its last write.
  `TC_ASSERT_NEXT(a_run_continues, strobe && !last, strobe, "write run broken before last")
  // Every run starts at the first column.
  `TC_ASSERT_NEXT(a_run_starts_first, !strobe || last, !strobe || ddram_address == ADDR_FIRST,
                  "write run does not start at first column")
  // The last flag and the last column go together.
  `TC_ASSERT_SAME(a_last_column, strobe, last == (ddram_address == ADDR_LAST),
                  "last flag disagrees with column")

endmodule

[hw/rtl/tc2lcd_front.sv]
// Front end: accepts frames, converts the reading to decimal digits in a pipeline.
`timescale 1ns / 1ps

module tc2lcd_front
  import tc2lcd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] raw_frame,
  input  logic        pop,
  output logic        busy,
  output entry_t      push
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] used_next;
  logic             accept;
  logic [4:0]       stage_valid;

  // stage 1
  logic [READING_W-1:0] reading;
  // stage 2
  logic [3:0] s2_d3;
  logic [9:0] s2_rem;
  logic [3:0] s2_tenths;
  // stage 3
  logic [3:0] s3_d3, s3_d2, s3_tenths;
  logic [9:0] s3_rem;
  // stage 4
  logic [3:0] s4_d3, s4_d2, s4_tenths;
  logic [6:0] s4_r2;
  // stage 5
  logic [3:0] s5_d3, s5_d2, s5_d1, s5_tenths;
  logic [6:0] s5_r2;

  logic [9:0]  whole;
  logic [3:0]  tenths_next;
  logic [15:0] hund_prod;
  logic [10:0] hund_back;
  logic [14:0] tens_prod;
  logic [7:0]  tens_back;

  // Credits cover items in the pipeline plus items in the queue.
  assign accept = start && !busy;
  assign busy   = (used == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    used_next = used;
    if (accept && !pop) begin
      used_next = used + CNT_W'(1);
    end else if (!accept && pop) begin
      used_next = used - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= '0;
      stage_valid <= '0;
    end else begin
      used        <= used_next;
      stage_valid <= {stage_valid[3:0], accept};
    end
  end

  assign whole = reading[READING_W-1:2];

  // Tenths of the quarter-degree fraction, truncated: 0, .25, .5, .75.
  always_comb begin
    case (reading[1:0])
      2'd0:    tenths_next = 4'd0;
      2'd1:    tenths_next = 4'd2;
      2'd2:    tenths_next = 4'd5;
      2'd3:    tenths_next = 4'd7;
      default: tenths_next = 4'd0;
    endcase
  end

  // x*41 >> 12 equals x/100 for x below 1000; x*205 >> 11 equals x/10 below 100.
  assign hund_prod = {6'd0, s2_rem} * 16'd41;
  assign hund_back = {7'd0, s3_d2} * 11'd100;
  assign tens_prod = {8'd0, s4_r2} * 15'd205;
  assign tens_back = {4'd0, s5_d1} * 8'd10;

  always_ff @(posedge clk) begin
    if (accept) begin
      reading <= raw_frame[14:3];
    end
    s2_tenths <= tenths_next;
    if (whole >= 10'd1000) begin
      s2_d3  <= 4'd1;
      s2_rem <= whole - 10'd1000;
    end else begin
      s2_d3  <= 4'd0;
      s2_rem <= whole;
    end
    s3_d3     <= s2_d3;
    s3_tenths <= s2_tenths;
    s3_rem    <= s2_rem;
    s3_d2     <= hund_prod[15:12];
    s4_d3     <= s3_d3;
    s4_d2     <= s3_d2;
    s4_tenths <= s3_tenths;
    s4_r2     <= 7'(s3_rem - hund_back[9:0]);
    s5_d3     <= s4_d3;
    s5_d2     <= s4_d2;
    s5_tenths <= s4_tenths;
    s5_r2     <= s4_r2;
    s5_d1     <= tens_prod[14:11];
  end

  always_comb begin
    push.valid         = stage_valid[4];
    push.digits.d3     = s5_d3;
    push.digits.d2     = s5_d2;
    push.digits.d1     = s5_d1;
    push.digits.d0     = 4'(s5_r2 - tens_back[6:0]);
    push.digits.tenths = s5_tenths;
  end

endmodule

[hw/rtl/tc2lcd_queue.sv]
// Short digit queue between the conversion front end and the write sequencer.
`timescale 1ns / 1ps

module tc2lcd_queue
  import tc2lcd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  entry_t push,
  input  logic   pop,
  output entry_t head
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  digits_t          slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.digits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (push.valid && !pop) begin
        count <= count + CNT_W'(1);
      end else if (!push.valid && pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign head.valid  = (count != '0);
  assign head.digits = slots[rd_ptr];

endmodule

[hw/rtl/tc2lcd_back.sv]
// Back end: steps through the eight LCD writes of each queued reading.
`timescale 1ns / 1ps

module tc2lcd_back
  import tc2lcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  output logic       pop,
  output logic       strobe,
  output logic [7:0] ddram_address,
  output logic [7:0] char_code,
  output logic       last
);

  logic             active;
  logic [COL_W-1:0] col;
  digits_t          cur;
  logic [7:0]       char_next;
  logic             run_done;

  assign run_done = !active || (col == COL_UNIT);
  assign pop      = run_done && head.valid;

  always_comb begin
    case (col)
      COL_THOUSANDS: char_next = (cur.d3 == 4'd0) ? ASCII_SPACE : ASCII_ZERO + {4'd0, cur.d3};
      COL_HUNDREDS:  char_next = (cur.d3 == 4'd0 && cur.d2 == 4'd0) ?
                                 ASCII_SPACE : ASCII_ZERO + {4'd0, cur.d2};
      COL_TENS:      char_next = (cur.d3 == 4'd0 && cur.d2 == 4'd0 && cur.d1 == 4'd0) ?
                                 ASCII_SPACE : ASCII_ZERO + {4'd0, cur.d1};
      COL_ONES:      char_next = ASCII_ZERO + {4'd0, cur.d0};
      COL_DOT:       char_next = ASCII_DOT;
      COL_TENTHS:    char_next = ASCII_ZERO + {4'd0, cur.tenths};
      COL_DEGREE:    char_next = DEGREE_SIGN;
      COL_UNIT:      char_next = ASCII_C;
      default:       char_next = ASCII_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      col    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
        col    <= COL_THOUSANDS;
      end else if (run_done) begin
        active <= 1'b0;
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.digits;
    end
    ddram_address <= ADDR_FIRST + {5'd0, col};
    char_code     <= char_next;
    last          <= (col == COL_UNIT);
  end

endmodule
